// ----- design/ecv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecv_pkg
// Widths, types and helpers shared by the elastic collision velocity core.
// ----------------------------------------------------------------------------
package ecv_pkg;

  localparam int WORD_BITS  = 24;
  localparam int MASS_BITS  = 16;
  localparam int DIFF_BITS  = WORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int DOT_BITS   = PROD_BITS + 1;
  localparam int MSUM_BITS  = MASS_BITS + 1;
  localparam int DEN_BITS   = DOT_BITS + MSUM_BITS;
  localparam int D2_BITS    = DEN_BITS + 1;
  localparam int CM_BITS    = DIFF_BITS + MASS_BITS;
  localparam int LO_BITS    = (DOT_BITS + 1) / 2;
  localparam int HI_BITS    = DOT_BITS - LO_BITS;
  localparam int NUM_BITS   = DOT_BITS + CM_BITS;
  localparam int N_BITS     = NUM_BITS + 3;
  // |delta| < 2*sqrt(2)*2^WORD_BITS by Cauchy-Schwarz, so this quotient width
  // never overflows and no clamp is needed
  localparam int Q_BITS     = WORD_BITS + 2;
  localparam int DELTA_BITS = Q_BITS + 1;
  localparam int SUM_BITS   = DELTA_BITS + 1;
  localparam int LANES      = 4;

  // lane order of the four velocity changes
  localparam int LANE_FIRST_X  = 0;
  localparam int LANE_FIRST_Y  = 1;
  localparam int LANE_SECOND_X = 2;
  localparam int LANE_SECOND_Y = 3;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [DIFF_BITS-1:0] diff_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;
  typedef logic [MASS_BITS-1:0]        mass_t;

  typedef struct packed {
    word_t first_vel_x;
    word_t first_vel_y;
    word_t second_vel_x;
    word_t second_vel_y;
    word_t first_pos_x;
    word_t first_pos_y;
    word_t second_pos_x;
    word_t second_pos_y;
    mass_t first_mass;
    mass_t second_mass;
  } in_item_t;

  // travels alongside the arithmetic
  typedef struct packed {
    word_t            v1x;
    word_t            v1y;
    word_t            v2x;
    word_t            v2y;
    logic             degen;
    logic             bypass;
    logic [LANES-1:0] neg;
  } side_t;

  function automatic word_t sat_word(logic signed [SUM_BITS-1:0] s);
    word_t r;
    if (s[SUM_BITS-1:WORD_BITS-1] == '0 || s[SUM_BITS-1:WORD_BITS-1] == '1) begin
      r = s[WORD_BITS-1:0];
    end else if (s[SUM_BITS-1]) begin
      r = {1'b1, {(WORD_BITS-1){1'b0}}};
    end else begin
      r = {1'b0, {(WORD_BITS-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ----- design/ecv_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecv_in_if
// Input channel: two bodies' velocities, centres and masses.
// ----------------------------------------------------------------------------
interface ecv_in_if;
  logic              valid;
  logic              ready;
  ecv_pkg::word_t    first_vel_x;
  ecv_pkg::word_t    first_vel_y;
  ecv_pkg::word_t    second_vel_x;
  ecv_pkg::word_t    second_vel_y;
  ecv_pkg::word_t    first_pos_x;
  ecv_pkg::word_t    first_pos_y;
  ecv_pkg::word_t    second_pos_x;
  ecv_pkg::word_t    second_pos_y;
  ecv_pkg::mass_t    first_mass;
  ecv_pkg::mass_t    second_mass;

  modport source (
    output valid, first_vel_x, first_vel_y, second_vel_x, second_vel_y,
           first_pos_x, first_pos_y, second_pos_x, second_pos_y,
           first_mass, second_mass,
    input  ready
  );
  modport sink (
    input  valid, first_vel_x, first_vel_y, second_vel_x, second_vel_y,
           first_pos_x, first_pos_y, second_pos_x, second_pos_y,
           first_mass, second_mass,
    output ready
  );
endinterface

// ----- design/ecv_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecv_out_if
// Output channel: velocities after the collision and the degenerate flag.
// ----------------------------------------------------------------------------
interface ecv_out_if;
  logic           valid;
  logic           ready;
  ecv_pkg::word_t new_first_vel_x;
  ecv_pkg::word_t new_first_vel_y;
  ecv_pkg::word_t new_second_vel_x;
  ecv_pkg::word_t new_second_vel_y;
  logic           degenerate;

  modport source (
    output valid, new_first_vel_x, new_first_vel_y, new_second_vel_x,
           new_second_vel_y, degenerate,
    input  ready
  );
  modport sink (
    input  valid, new_first_vel_x, new_first_vel_y, new_second_vel_x,
           new_second_vel_y, degenerate,
    output ready
  );
endinterface

// ----- design/ecv_prep.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecv_prep
// Seven-stage front end: differences, dot product, |d|^2, mass products and
// the exact numerator/denominator of each of the four velocity changes.
// ----------------------------------------------------------------------------
module ecv_prep (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         advance,
  input  logic                                         in_valid,
  input  ecv_pkg::in_item_t                            item,
  output logic                                         out_valid,
  output logic [ecv_pkg::LANES-1:0][ecv_pkg::N_BITS-1:0] num,
  output logic [ecv_pkg::D2_BITS-1:0]                  d2,
  output ecv_pkg::side_t                               side
);

  logic [6:0] vld;

  // stage 1
  ecv_pkg::diff_t  dx1, dy1, dvx1, dvy1;
  ecv_pkg::mass_t  m1_1, m2_1;
  ecv_pkg::side_t  sd1;
  // stage 2
  ecv_pkg::prod_t  pxx2, pyy2, sxx2, syy2;
  logic [ecv_pkg::DIFF_BITS-1:0] magx2, magy2;
  logic            negx2, negy2, degen2;
  logic [ecv_pkg::MSUM_BITS-1:0] msum2, msum3;
  ecv_pkg::mass_t  m1_2, m2_2;
  ecv_pkg::side_t  sd2, sd3, sd4, sd5, sd6;
  // stage 3
  logic signed [ecv_pkg::DOT_BITS-1:0] dot3;
  logic [ecv_pkg::DOT_BITS-1:0]        dsq3;
  logic [ecv_pkg::LANES-1:0][ecv_pkg::CM_BITS-1:0] cm3, cm4;
  logic            negx3, negy3;
  // stage 4
  logic [ecv_pkg::DOT_BITS-1:0] dotmag4;
  logic [ecv_pkg::DEN_BITS-1:0] den4, den5, den6;
  // stage 5
  logic [ecv_pkg::LANES-1:0][ecv_pkg::LO_BITS+ecv_pkg::CM_BITS-1:0] plo5;
  logic [ecv_pkg::LANES-1:0][ecv_pkg::HI_BITS+ecv_pkg::CM_BITS-1:0] phi5;
  // stage 6
  logic [ecv_pkg::LANES-1:0][ecv_pkg::NUM_BITS-1:0] num6;

  logic dotneg3;
  assign dotneg3 = dot3[ecv_pkg::DOT_BITS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[5:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      // stage 1: differences
      dx1  <= ecv_pkg::diff_t'(item.first_pos_x) - ecv_pkg::diff_t'(item.second_pos_x);
      dy1  <= ecv_pkg::diff_t'(item.first_pos_y) - ecv_pkg::diff_t'(item.second_pos_y);
      dvx1 <= ecv_pkg::diff_t'(item.first_vel_x) - ecv_pkg::diff_t'(item.second_vel_x);
      dvy1 <= ecv_pkg::diff_t'(item.first_vel_y) - ecv_pkg::diff_t'(item.second_vel_y);
      m1_1 <= item.first_mass;
      m2_1 <= item.second_mass;
      sd1.v1x    <= item.first_vel_x;
      sd1.v1y    <= item.first_vel_y;
      sd1.v2x    <= item.second_vel_x;
      sd1.v2y    <= item.second_vel_y;
      sd1.degen  <= 1'b0;
      sd1.bypass <= 1'b0;
      sd1.neg    <= '0;

      // stage 2: products and magnitudes
      pxx2   <= ecv_pkg::prod_t'(dvx1) * ecv_pkg::prod_t'(dx1);
      pyy2   <= ecv_pkg::prod_t'(dvy1) * ecv_pkg::prod_t'(dy1);
      sxx2   <= ecv_pkg::prod_t'(dx1) * ecv_pkg::prod_t'(dx1);
      syy2   <= ecv_pkg::prod_t'(dy1) * ecv_pkg::prod_t'(dy1);
      negx2  <= dx1[ecv_pkg::DIFF_BITS-1];
      negy2  <= dy1[ecv_pkg::DIFF_BITS-1];
      magx2  <= dx1[ecv_pkg::DIFF_BITS-1] ? -dx1 : dx1;
      magy2  <= dy1[ecv_pkg::DIFF_BITS-1] ? -dy1 : dy1;
      degen2 <= (dx1 == '0) && (dy1 == '0);
      msum2  <= ecv_pkg::MSUM_BITS'(m1_1) + ecv_pkg::MSUM_BITS'(m2_1);
      m1_2   <= m1_1;
      m2_2   <= m2_1;
      sd2    <= sd1;

      // stage 3: dot product, |d|^2, component times mass
      dot3  <= ecv_pkg::DOT_BITS'(pxx2) + ecv_pkg::DOT_BITS'(pyy2);
      dsq3  <= {1'b0, sxx2} + {1'b0, syy2};
      cm3[ecv_pkg::LANE_FIRST_X]  <= ecv_pkg::CM_BITS'(magx2) * ecv_pkg::CM_BITS'(m2_2);
      cm3[ecv_pkg::LANE_FIRST_Y]  <= ecv_pkg::CM_BITS'(magy2) * ecv_pkg::CM_BITS'(m2_2);
      cm3[ecv_pkg::LANE_SECOND_X] <= ecv_pkg::CM_BITS'(magx2) * ecv_pkg::CM_BITS'(m1_2);
      cm3[ecv_pkg::LANE_SECOND_Y] <= ecv_pkg::CM_BITS'(magy2) * ecv_pkg::CM_BITS'(m1_2);
      negx3 <= negx2;
      negy3 <= negy2;
      msum3 <= msum2;
      sd3.v1x    <= sd2.v1x;
      sd3.v1y    <= sd2.v1y;
      sd3.v2x    <= sd2.v2x;
      sd3.v2y    <= sd2.v2y;
      sd3.degen  <= degen2;
      sd3.bypass <= degen2 || (msum2 == '0);
      sd3.neg    <= sd2.neg;

      // stage 4: dot magnitude, denominator, signs
      dotmag4 <= dotneg3 ? -dot3 : dot3;
      den4    <= ecv_pkg::DEN_BITS'(dsq3) * ecv_pkg::DEN_BITS'(msum3);
      cm4     <= cm3;
      sd4.v1x    <= sd3.v1x;
      sd4.v1y    <= sd3.v1y;
      sd4.v2x    <= sd3.v2x;
      sd4.v2y    <= sd3.v2y;
      sd4.degen  <= sd3.degen;
      sd4.bypass <= sd3.bypass;
      sd4.neg[ecv_pkg::LANE_FIRST_X]  <= dotneg3 ^ negx3;
      sd4.neg[ecv_pkg::LANE_FIRST_Y]  <= dotneg3 ^ negy3;
      sd4.neg[ecv_pkg::LANE_SECOND_X] <= dotneg3 ^ negx3;
      sd4.neg[ecv_pkg::LANE_SECOND_Y] <= dotneg3 ^ negy3;

      // stage 5: split product of |dot| by component*mass
      for (int l = 0; l < ecv_pkg::LANES; l++) begin
        plo5[l] <= (ecv_pkg::LO_BITS+ecv_pkg::CM_BITS)'(dotmag4[ecv_pkg::LO_BITS-1:0])
                   * (ecv_pkg::LO_BITS+ecv_pkg::CM_BITS)'(cm4[l]);
        phi5[l] <= (ecv_pkg::HI_BITS+ecv_pkg::CM_BITS)'(
                     dotmag4[ecv_pkg::DOT_BITS-1:ecv_pkg::LO_BITS])
                   * (ecv_pkg::HI_BITS+ecv_pkg::CM_BITS)'(cm4[l]);
      end
      den5 <= den4;
      sd5  <= sd4;

      // stage 6: recombine partial products
      for (int l = 0; l < ecv_pkg::LANES; l++) begin
        num6[l] <= (ecv_pkg::NUM_BITS'(phi5[l]) << ecv_pkg::LO_BITS)
                   + ecv_pkg::NUM_BITS'(plo5[l]);
      end
      den6 <= den5;
      sd6  <= sd5;

      // stage 7: 4*mo*dot*comp + den over 2*den gives the rounded change
      for (int l = 0; l < ecv_pkg::LANES; l++) begin
        num[l] <= (ecv_pkg::N_BITS'(num6[l]) << 2) + ecv_pkg::N_BITS'(den6);
      end
      d2   <= {den6, 1'b0};
      side <= sd6;
    end
  end

  assign out_valid = vld[6];

endmodule

// ----- design/ecv_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecv_div
// Four-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ecv_div (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           advance,
  input  logic                                           in_valid,
  input  logic [ecv_pkg::LANES-1:0][ecv_pkg::N_BITS-1:0] num,
  input  logic [ecv_pkg::D2_BITS-1:0]                    d2,
  input  ecv_pkg::side_t                                 in_side,
  output logic                                           out_valid,
  output logic [ecv_pkg::LANES-1:0][ecv_pkg::Q_BITS-1:0] quo,
  output ecv_pkg::side_t                                 out_side
);

  typedef struct packed {
    logic [ecv_pkg::D2_BITS-1:0] rem;
    logic [ecv_pkg::Q_BITS-1:0]  nlo;
    logic [ecv_pkg::Q_BITS-1:0]  q;
  } lane_t;

  function automatic lane_t div_step(lane_t a, logic [ecv_pkg::D2_BITS-1:0] d);
    logic [ecv_pkg::D2_BITS+1:0] t;
    logic [ecv_pkg::D2_BITS+1:0] diff;
    lane_t r;
    t    = {1'b0, a.rem, a.nlo[ecv_pkg::Q_BITS-1]};
    diff = t - {2'b00, d};
    r.nlo = {a.nlo[ecv_pkg::Q_BITS-2:0], 1'b0};
    if (diff[ecv_pkg::D2_BITS+1]) begin
      r.rem = t[ecv_pkg::D2_BITS-1:0];
      r.q   = {a.q[ecv_pkg::Q_BITS-2:0], 1'b0};
    end else begin
      r.rem = diff[ecv_pkg::D2_BITS-1:0];
      r.q   = {a.q[ecv_pkg::Q_BITS-2:0], 1'b1};
    end
    return r;
  endfunction

  lane_t                       pipe_lane [ecv_pkg::Q_BITS][ecv_pkg::LANES];
  logic [ecv_pkg::D2_BITS-1:0] pipe_d2   [ecv_pkg::Q_BITS];
  ecv_pkg::side_t              pipe_side [ecv_pkg::Q_BITS];
  logic [ecv_pkg::Q_BITS-1:0]  pipe_vld;

  for (genvar s = 0; s < ecv_pkg::Q_BITS; s++) begin : g_stage
    lane_t                       src_lane [ecv_pkg::LANES];
    logic [ecv_pkg::D2_BITS-1:0] src_d2;
    ecv_pkg::side_t              src_side;
    logic                        src_vld;

    if (s == 0) begin : g_head
      // quotient fits in Q_BITS, so the top bits start below the divisor
      for (genvar l = 0; l < ecv_pkg::LANES; l++) begin : g_lane
        assign src_lane[l].rem = num[l][ecv_pkg::N_BITS-1:ecv_pkg::Q_BITS];
        assign src_lane[l].nlo = num[l][ecv_pkg::Q_BITS-1:0];
        assign src_lane[l].q   = '0;
      end
      assign src_d2   = d2;
      assign src_side = in_side;
      assign src_vld  = in_valid;
    end else begin : g_body
      for (genvar l = 0; l < ecv_pkg::LANES; l++) begin : g_lane
        assign src_lane[l] = pipe_lane[s-1][l];
      end
      assign src_d2   = pipe_d2[s-1];
      assign src_side = pipe_side[s-1];
      assign src_vld  = pipe_vld[s-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        pipe_vld[s] <= 1'b0;
      end else if (advance) begin
        pipe_vld[s] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        for (int l = 0; l < ecv_pkg::LANES; l++) begin
          pipe_lane[s][l] <= div_step(src_lane[l], src_d2);
        end
        pipe_d2[s]   <= src_d2;
        pipe_side[s] <= src_side;
      end
    end
  end

  for (genvar l = 0; l < ecv_pkg::LANES; l++) begin : g_out
    assign quo[l] = pipe_lane[ecv_pkg::Q_BITS-1][l].q;
  end
  assign out_valid = pipe_vld[ecv_pkg::Q_BITS-1];
  assign out_side  = pipe_side[ecv_pkg::Q_BITS-1];

endmodule

// ----- design/elastic_collision_2d_velocity_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elastic_collision_2d_velocity_core
// Velocities of two bodies after a 2D elastic collision, exact fixed point
// with one rounding per velocity change and saturation to the word range.
// ----------------------------------------------------------------------------
//  channel  direction  payload
//  sample   in         velocities, centres, masses of both bodies
//  result   out        new velocities, degenerate flag
//
// One transaction per cycle sustained while result is ready; 7 arithmetic
// stages, 26 divider stages (one quotient bit each), 1 output register.
// rst clears all valid bits; payload registers are not reset.
// A stall on result freezes the whole pipeline; sample.ready drops with it.
// ----------------------------------------------------------------------------
module elastic_collision_2d_velocity_core (
  input  logic      clk,
  input  logic      rst,
  ecv_in_if.sink    sample,
  ecv_out_if.source result
);

  logic              advance;
  ecv_pkg::in_item_t item;

  logic                                           prep_valid;
  logic [ecv_pkg::LANES-1:0][ecv_pkg::N_BITS-1:0] prep_num;
  logic [ecv_pkg::D2_BITS-1:0]                    prep_d2;
  ecv_pkg::side_t                                 prep_side;

  logic                                           div_valid;
  logic [ecv_pkg::LANES-1:0][ecv_pkg::Q_BITS-1:0] div_quo;
  ecv_pkg::side_t                                 div_side;

  logic signed [ecv_pkg::DELTA_BITS-1:0] delta [ecv_pkg::LANES];

  logic           out_valid;
  ecv_pkg::word_t out_v1x, out_v1y, out_v2x, out_v2y;
  logic           out_degen;

  assign advance      = !out_valid || result.ready;
  assign sample.ready = advance;

  assign item.first_vel_x  = sample.first_vel_x;
  assign item.first_vel_y  = sample.first_vel_y;
  assign item.second_vel_x = sample.second_vel_x;
  assign item.second_vel_y = sample.second_vel_y;
  assign item.first_pos_x  = sample.first_pos_x;
  assign item.first_pos_y  = sample.first_pos_y;
  assign item.second_pos_x = sample.second_pos_x;
  assign item.second_pos_y = sample.second_pos_y;
  assign item.first_mass   = sample.first_mass;
  assign item.second_mass  = sample.second_mass;

  ecv_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (sample.valid),
    .item      (item),
    .out_valid (prep_valid),
    .num       (prep_num),
    .d2        (prep_d2),
    .side      (prep_side)
  );

  ecv_div u_div (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (prep_valid),
    .num       (prep_num),
    .d2        (prep_d2),
    .in_side   (prep_side),
    .out_valid (div_valid),
    .quo       (div_quo),
    .out_side  (div_side)
  );

  // coincident centres or zero total mass: no change
  always_comb begin
    for (int l = 0; l < ecv_pkg::LANES; l++) begin
      if (div_side.bypass) begin
        delta[l] = '0;
      end else if (div_side.neg[l]) begin
        delta[l] = -$signed({1'b0, div_quo[l]});
      end else begin
        delta[l] = $signed({1'b0, div_quo[l]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_v1x <= ecv_pkg::sat_word(ecv_pkg::SUM_BITS'(div_side.v1x)
                 - ecv_pkg::SUM_BITS'(delta[ecv_pkg::LANE_FIRST_X]));
      out_v1y <= ecv_pkg::sat_word(ecv_pkg::SUM_BITS'(div_side.v1y)
                 - ecv_pkg::SUM_BITS'(delta[ecv_pkg::LANE_FIRST_Y]));
      out_v2x <= ecv_pkg::sat_word(ecv_pkg::SUM_BITS'(div_side.v2x)
                 + ecv_pkg::SUM_BITS'(delta[ecv_pkg::LANE_SECOND_X]));
      out_v2y <= ecv_pkg::sat_word(ecv_pkg::SUM_BITS'(div_side.v2y)
                 + ecv_pkg::SUM_BITS'(delta[ecv_pkg::LANE_SECOND_Y]));
      out_degen <= div_side.degen;
    end
  end

  assign result.valid            = out_valid;
  assign result.new_first_vel_x  = out_v1x;
  assign result.new_first_vel_y  = out_v1y;
  assign result.new_second_vel_x = out_v2x;
  assign result.new_second_vel_y = out_v2y;
  assign result.degenerate       = out_degen;

`ifndef SYNTHESIS
  a_reset_clears: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid right after reset");

  a_degen_bypass: assert property (@(posedge clk) disable iff (rst)
    (div_valid && div_side.degen) |-> div_side.bypass)
    else $error("coincident centres not bypassed");

  a_bypass_pass: assert property (@(posedge clk) disable iff (rst)
    (div_valid && advance && div_side.bypass) |=>
      (result.new_first_vel_x == $past(div_side.v1x) &&
       result.new_second_vel_y == $past(div_side.v2y)))
    else $error("bypassed transaction changed velocity");

  a_moves_out: assert property (@(posedge clk) disable iff (rst)
    (div_valid && advance) |=> result.valid)
    else $error("transaction lost at output register");
`endif

endmodule

// ----- verif/elastic_collision_2d_velocity_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elastic_collision_2d_velocity_checker
// Watches both channels of the collision core, computes the velocities after
// each accepted transaction with exact wide arithmetic and compares them,
// field by field and in order, with the results the core delivers.
// ----------------------------------------------------------------------------
module elastic_collision_2d_velocity_checker (
  input  logic clk,
  input  logic rst,
  ecv_in_if    sample,
  ecv_out_if   result,
  output int   errors,
  output int   pending
);

  typedef struct packed {
    ecv_pkg::word_t vx1;
    ecv_pkg::word_t vy1;
    ecv_pkg::word_t vx2;
    ecv_pkg::word_t vy2;
    logic           degen;
  } velocities_t;

  localparam logic [159:0] DELTA_CAP = 160'(1) << 40;

  velocities_t after_collision_q[$];

  initial errors = 0;
  assign pending = after_collision_q.size();

  // round(2*mo*dot*comp / den), halves away from zero, magnitude capped
  function automatic longint velocity_change(longint dot_mag, logic dot_neg, longint comp,
                                             longint mo, logic [159:0] den);
    logic [159:0] num;
    logic [159:0] q;
    longint       m;
    num = 160'(dot_mag) * 160'(comp < 0 ? -comp : comp) * 160'(4 * mo);
    q = (num + den) / (den << 1);
    if (q > DELTA_CAP) q = DELTA_CAP;
    m = longint'(q[63:0]);
    return (dot_neg != (comp < 0)) ? -m : m;
  endfunction

  function automatic ecv_pkg::word_t clamp_word(longint v);
    if (v > 64'sd8388607) return ecv_pkg::word_t'(24'h7FFFFF);
    if (v < -64'sd8388608) return ecv_pkg::word_t'(24'h800000);
    return ecv_pkg::word_t'(v);
  endfunction

  function automatic velocities_t collide(ecv_pkg::in_item_t s);
    longint       v1x, v1y, v2x, v2y, dx, dy, dot, dot_mag, dsq, m1, m2, msum;
    longint       c1x, c1y, c2x, c2y;
    logic [159:0] den;
    velocities_t  r;
    v1x = s.first_vel_x;
    v1y = s.first_vel_y;
    v2x = s.second_vel_x;
    v2y = s.second_vel_y;
    dx = longint'(s.first_pos_x) - longint'(s.second_pos_x);
    dy = longint'(s.first_pos_y) - longint'(s.second_pos_y);
    m1 = s.first_mass;
    m2 = s.second_mass;
    msum = m1 + m2;
    c1x = 0; c1y = 0; c2x = 0; c2y = 0;
    r.degen = (dx == 0 && dy == 0);
    if (!r.degen && msum != 0) begin
      dot = (v1x - v2x) * dx + (v1y - v2y) * dy;
      dot_mag = dot < 0 ? -dot : dot;
      dsq = dx * dx + dy * dy;
      den = 160'(dsq) * 160'(msum);
      c1x = velocity_change(dot_mag, dot < 0, dx, m2, den);
      c1y = velocity_change(dot_mag, dot < 0, dy, m2, den);
      c2x = velocity_change(dot_mag, dot < 0, dx, m1, den);
      c2y = velocity_change(dot_mag, dot < 0, dy, m1, den);
    end
    r.vx1 = clamp_word(v1x - c1x);
    r.vy1 = clamp_word(v1y - c1y);
    r.vx2 = clamp_word(v2x + c2x);
    r.vy2 = clamp_word(v2y + c2y);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t MISMATCH %s: got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    ecv_pkg::in_item_t s;
    velocities_t       e;
    if (!rst && sample.valid && sample.ready) begin
      s.first_vel_x  = sample.first_vel_x;
      s.first_vel_y  = sample.first_vel_y;
      s.second_vel_x = sample.second_vel_x;
      s.second_vel_y = sample.second_vel_y;
      s.first_pos_x  = sample.first_pos_x;
      s.first_pos_y  = sample.first_pos_y;
      s.second_pos_x = sample.second_pos_x;
      s.second_pos_y = sample.second_pos_y;
      s.first_mass   = sample.first_mass;
      s.second_mass  = sample.second_mass;
      after_collision_q.push_back(collide(s));
    end
    if (!rst && result.valid && result.ready) begin
      if (after_collision_q.size() == 0) begin
        report_mismatch("unexpected transaction", 1, 0);
      end else begin
        e = after_collision_q.pop_front();
        if (result.new_first_vel_x !== e.vx1)
          report_mismatch("new_first_vel_x", result.new_first_vel_x, e.vx1);
        if (result.new_first_vel_y !== e.vy1)
          report_mismatch("new_first_vel_y", result.new_first_vel_y, e.vy1);
        if (result.new_second_vel_x !== e.vx2)
          report_mismatch("new_second_vel_x", result.new_second_vel_x, e.vx2);
        if (result.new_second_vel_y !== e.vy2)
          report_mismatch("new_second_vel_y", result.new_second_vel_y, e.vy2);
        if (result.degenerate !== e.degen)
          report_mismatch("degenerate", result.degenerate, e.degen);
      end
    end
  end

endmodule

// ----- verif/elastic_collision_2d_velocity_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elastic_collision_2d_velocity_core_test
// Drives directed and random body pairs into the collision core under random
// sender and receiver idling plus one long receiver hold-off; the checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module elastic_collision_2d_velocity_core_test;

  localparam int CYCLE_LIMIT = 300000;
  localparam int LATENCY     = 34;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors, pending, cycles = 0;
  int   src_idle_pct = 8;
  int   rx_idle_pct  = 71;
  bit   long_hold    = 1'b0;

  ecv_in_if  sample ();
  ecv_out_if result ();

  elastic_collision_2d_velocity_core u_dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample),
    .result (result)
  );

  elastic_collision_2d_velocity_checker u_checker (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample),
    .result  (result),
    .errors  (errors),
    .pending (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    result.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        long_hold = 1'b0;
        result.ready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      result.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic ecv_pkg::word_t pick_word();
    case ($urandom_range(9))
      0:       return ecv_pkg::word_t'(24'h7FFFFF);
      1:       return ecv_pkg::word_t'(24'h800000);
      2, 3:    return ecv_pkg::word_t'($urandom_range(2047) - 1024);
      4, 5:    return ecv_pkg::word_t'($urandom_range(131071) - 65536);
      default: return ecv_pkg::word_t'($urandom);
    endcase
  endfunction

  function automatic ecv_pkg::mass_t pick_mass();
    case ($urandom_range(19))
      0:       return ecv_pkg::mass_t'(0);
      1:       return ecv_pkg::mass_t'(16'hFFFF);
      2:       return ecv_pkg::mass_t'(1);
      3, 4, 5: return ecv_pkg::mass_t'($urandom_range(16, 1));
      default: return ecv_pkg::mass_t'($urandom_range(65535, 1));
    endcase
  endfunction

  function automatic ecv_pkg::in_item_t random_pair();
    ecv_pkg::in_item_t s;
    s.first_vel_x  = pick_word();
    s.first_vel_y  = pick_word();
    s.second_vel_x = pick_word();
    s.second_vel_y = pick_word();
    s.first_pos_x  = pick_word();
    s.first_pos_y  = pick_word();
    case ($urandom_range(9))
      0: begin  // coincident centres
        s.second_pos_x = s.first_pos_x;
        s.second_pos_y = s.first_pos_y;
      end
      1, 2, 3: begin  // nearby centres
        s.second_pos_x = s.first_pos_x + ecv_pkg::word_t'($urandom_range(1023) - 512);
        s.second_pos_y = s.first_pos_y + ecv_pkg::word_t'($urandom_range(1023) - 512);
      end
      default: begin
        s.second_pos_x = pick_word();
        s.second_pos_y = pick_word();
      end
    endcase
    s.first_mass  = pick_mass();
    s.second_mass = pick_mass();
    return s;
  endfunction

  function automatic ecv_pkg::in_item_t make_pair(int v1x, int v1y, int v2x, int v2y,
                                                  int p1x, int p1y, int p2x, int p2y,
                                                  int m1, int m2);
    ecv_pkg::in_item_t s;
    s.first_vel_x  = ecv_pkg::word_t'(v1x);
    s.first_vel_y  = ecv_pkg::word_t'(v1y);
    s.second_vel_x = ecv_pkg::word_t'(v2x);
    s.second_vel_y = ecv_pkg::word_t'(v2y);
    s.first_pos_x  = ecv_pkg::word_t'(p1x);
    s.first_pos_y  = ecv_pkg::word_t'(p1y);
    s.second_pos_x = ecv_pkg::word_t'(p2x);
    s.second_pos_y = ecv_pkg::word_t'(p2y);
    s.first_mass   = ecv_pkg::mass_t'(m1);
    s.second_mass  = ecv_pkg::mass_t'(m2);
    return s;
  endfunction

  // called at a rising edge; returns at the edge where the transaction is taken
  task automatic send_pair(ecv_pkg::in_item_t s);
    bit taken;
    if ($urandom_range(99) < src_idle_pct) begin
      sample.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    sample.valid        <= 1'b1;
    sample.first_vel_x  <= s.first_vel_x;
    sample.first_vel_y  <= s.first_vel_y;
    sample.second_vel_x <= s.second_vel_x;
    sample.second_vel_y <= s.second_vel_y;
    sample.first_pos_x  <= s.first_pos_x;
    sample.first_pos_y  <= s.first_pos_y;
    sample.second_pos_x <= s.second_pos_x;
    sample.second_pos_y <= s.second_pos_y;
    sample.first_mass   <= s.first_mass;
    sample.second_mass  <= s.second_mass;
    do begin
      @(negedge clk);
      taken = sample.ready;
      @(posedge clk);
    end while (!taken);
  endtask

  localparam int VMAX = 8388607;
  localparam int VMIN = -8388608;

  initial begin
    sample.valid        = 1'b0;
    sample.first_vel_x  = '0;
    sample.first_vel_y  = '0;
    sample.second_vel_x = '0;
    sample.second_vel_y = '0;
    sample.first_pos_x  = '0;
    sample.first_pos_y  = '0;
    sample.second_pos_x = '0;
    sample.second_pos_y = '0;
    sample.first_mass   = '0;
    sample.second_mass  = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed
    send_pair(make_pair(0, 0, 0, 0, 256, 0, 0, 0, 1, 1));
    send_pair(make_pair(256, 0, -256, 0, -256, 0, 256, 0, 5, 5));   // head-on, equal masses
    send_pair(make_pair(512, 128, -77, 33, 1000, 1000, 1000, 1000, 3, 9)); // coincident
    send_pair(make_pair(512, 128, -77, 33, 100, 7, -3, 50, 0, 0));  // both masses zero
    send_pair(make_pair(512, 128, -77, 33, 100, 7, -3, 50, 0, 40)); // first massless
    send_pair(make_pair(512, 128, -77, 33, 100, 7, -3, 50, 40, 0)); // second massless
    send_pair(make_pair(VMAX, VMAX, VMIN, VMIN, VMAX, VMAX, VMIN, VMIN, 65535, 65535));
    send_pair(make_pair(VMIN, VMIN, VMAX, VMAX, VMAX, VMIN, VMIN, VMAX, 1, 65535));
    send_pair(make_pair(VMAX, VMIN, VMIN, VMAX, VMIN, VMIN, VMAX, VMAX, 65535, 1));
    send_pair(make_pair(VMAX, 0, VMIN, 0, 1, 0, 0, 0, 1, 65535));
    send_pair(make_pair(VMIN, VMIN, VMIN, VMIN, VMIN, VMIN, VMIN, VMIN, 1, 1));
    send_pair(make_pair(VMAX, VMAX, VMAX, VMAX, VMAX, VMAX, VMAX, VMAX, 65535, 65535));
    send_pair(make_pair(-1, -1, 1, 1, 0, 1, 1, 0, 1, 2));           // tiny, dot product zero: no change
    send_pair(make_pair(3, 0, 0, 0, 1, 0, 0, 0, 1, 2));
    send_pair(make_pair(-3, 0, 0, 0, 1, 0, 0, 0, 1, 2));
    send_pair(make_pair(100, 300, -100, -300, 7, -9, -7, 9, 123, 4567));

    repeat (230) send_pair(random_pair());

    src_idle_pct = 71;
    rx_idle_pct  = 8;
    repeat (230) send_pair(random_pair());

    src_idle_pct = 0;
    rx_idle_pct  = 0;
    long_hold    = 1'b1;
    repeat (240) send_pair(random_pair());
    sample.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 16) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
